/* hw/rtl/cursor_doubly_linked_list_core_assert.svh */
// ----------------------------------------------------------------------------
// cursor list core assertion macros
// checks sampled on the rising clock edge, muted while reset is asserted
// ----------------------------------------------------------------------------
`ifndef CURSOR_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH
`define CURSOR_DOUBLY_LINKED_LIST_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CDLL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cdll assertion failed");

// consequent must hold in the cycle after the antecedent
`define CDLL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cdll assertion failed");

`endif

/* hw/rtl/cdll_pkg.sv */
// ----------------------------------------------------------------------------
// cdll_pkg
// shared constants, operation codes and control types of the cursor list core
// ----------------------------------------------------------------------------
package cdll_pkg;

  localparam int unsigned POOL_NODES_DEF = 256;
  localparam int unsigned ITEM_BITS_DEF  = 32;
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned OP_W           = 4;

  localparam logic [OP_W-1:0] OP_FIRST      = 4'd0;
  localparam logic [OP_W-1:0] OP_LAST       = 4'd1;
  localparam logic [OP_W-1:0] OP_NONE       = 4'd2;
  localparam logic [OP_W-1:0] OP_AFTER      = 4'd3;
  localparam logic [OP_W-1:0] OP_BEFORE     = 4'd4;
  localparam logic [OP_W-1:0] OP_GET        = 4'd5;
  localparam logic [OP_W-1:0] OP_SET        = 4'd6;
  localparam logic [OP_W-1:0] OP_INS_AFTER  = 4'd7;
  localparam logic [OP_W-1:0] OP_INS_BEFORE = 4'd8;
  localparam logic [OP_W-1:0] OP_DEL_AFTER  = 4'd9;
  localparam logic [OP_W-1:0] OP_DEL_BEFORE = 4'd10;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture operation and value
    logic read;    // read the cursor node and the free chain head
    logic exec;    // decode, first link writes, result capture
    logic link;    // second link writes of insert and delete
    logic finish;  // result goes out next cycle
  } cdll_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic link_needed;
  } cdll_sts_t;

endpackage

/* hw/rtl/cdll_ctrl.sv */
// ----------------------------------------------------------------------------
// cdll_ctrl
// operation sequencer: read, execute and an optional second link write step
// ----------------------------------------------------------------------------
module cdll_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cdll_pkg::cdll_sts_t sts_i,
  output cdll_pkg::cdll_cmd_t cmd_o,
  output logic                busy_o
);
  import cdll_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_LINK = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.link_needed) begin
          state_d = ST_LINK;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_LINK: begin
        cmd_o.link   = 1'b1;
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

/* hw/rtl/cdll_datapath.sv */
// ----------------------------------------------------------------------------
// cdll_datapath
// link and item memories, sentinel links, cursor, node allocator and results
// ----------------------------------------------------------------------------
module cdll_datapath #(
  parameter int unsigned POOL_NODES = cdll_pkg::POOL_NODES_DEF,
  parameter int unsigned ITEM_BITS  = cdll_pkg::ITEM_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cdll_pkg::cdll_cmd_t                   cmd_i,
  output cdll_pkg::cdll_sts_t                   sts_o,
  input  logic [cdll_pkg::OP_W-1:0]             operation_i,
  input  logic signed [cdll_pkg::DATA_W-1:0]    value_i,
  input  logic                                  cfg_we_i,
  input  logic signed [cdll_pkg::DATA_W-1:0]    cfg_wdata_i,
  output logic                                  done_o,
  output logic signed [cdll_pkg::DATA_W-1:0]    item_out_o,
  output logic                                  flag_o,
  output logic                                  pool_full_o
);
  import cdll_pkg::*;

  localparam int unsigned SLOTS  = POOL_NODES + 1;
  localparam int unsigned IDX_W  = $clog2(SLOTS);
  localparam int unsigned MARK_W = $clog2(SLOTS + 1);

  // node memories, entry 0 links live in head_q / tail_q
  logic [IDX_W-1:0]            next_mem [SLOTS];
  logic [IDX_W-1:0]            back_mem [SLOTS];
  logic signed [ITEM_BITS-1:0] item_mem [SLOTS];

  logic [IDX_W-1:0]            head_q, tail_q;
  logic [IDX_W-1:0]            cursor_q, cursor_d;
  logic [IDX_W-1:0]            free_head_q, free_head_d;
  logic [MARK_W-1:0]           fresh_q, fresh_d;
  logic signed [DATA_W-1:0]    default_q;
  logic                        done_q;

  logic [OP_W-1:0]             op_q;
  logic signed [ITEM_BITS-1:0] val_q;

  logic [IDX_W-1:0]            cur_next_q, cur_back_q, free_next_q;
  logic signed [ITEM_BITS-1:0] cur_item_q;

  logic [IDX_W-1:0]            node_q, node_d;
  logic [IDX_W-1:0]            prev_q, prev_d;
  logic [IDX_W-1:0]            succ_q, succ_d;

  logic signed [DATA_W-1:0]    res_item_q, res_item_d;
  logic                        res_flag_q, res_flag_d;
  logic                        res_full_q, res_full_d;

  logic                        nx_we, bk_we, it_we;
  logic [IDX_W-1:0]            nx_wa, bk_wa, it_wa;
  logic [IDX_W-1:0]            nx_wd, bk_wd;

  logic                        sel;
  logic [IDX_W-1:0]            c_next, c_back;
  logic                        alloc_ok;
  logic [IDX_W-1:0]            alloc_node;
  logic                        is_insert;

  assign sel       = (cursor_q != '0);
  assign c_next    = sel ? cur_next_q : head_q;
  assign c_back    = sel ? cur_back_q : tail_q;
  assign is_insert = (op_q == OP_INS_AFTER) || (op_q == OP_INS_BEFORE);

  // free chain first, then never used nodes
  always_comb begin
    alloc_ok   = 1'b0;
    alloc_node = '0;
    if (free_head_q != '0) begin
      alloc_ok   = 1'b1;
      alloc_node = free_head_q;
    end else if (fresh_q <= MARK_W'(POOL_NODES)) begin
      alloc_ok   = 1'b1;
      alloc_node = fresh_q[IDX_W-1:0];
    end
  end

  always_comb begin
    cursor_d          = cursor_q;
    free_head_d       = free_head_q;
    fresh_d           = fresh_q;
    node_d            = node_q;
    prev_d            = prev_q;
    succ_d            = succ_q;
    res_item_d        = res_item_q;
    res_flag_d        = res_flag_q;
    res_full_d        = res_full_q;
    nx_we             = 1'b0;
    nx_wa             = '0;
    nx_wd             = '0;
    bk_we             = 1'b0;
    bk_wa             = '0;
    bk_wd             = '0;
    it_we             = 1'b0;
    it_wa             = '0;
    sts_o.link_needed = 1'b0;

    if (cmd_i.exec) begin
      res_item_d = '0;
      res_flag_d = 1'b0;
      res_full_d = 1'b0;
      case (op_q)
        OP_FIRST: begin
          if (head_q != '0) cursor_d = head_q;
        end
        OP_LAST: begin
          if (head_q != '0) cursor_d = tail_q;
        end
        OP_NONE: begin
          res_flag_d = !sel;
        end
        OP_AFTER, OP_BEFORE: begin
          if (sel) begin
            cursor_d   = (op_q == OP_AFTER) ? c_next : c_back;
            res_flag_d = 1'b1;
          end
        end
        OP_GET: begin
          res_item_d = sel ? DATA_W'(cur_item_q) : default_q;
        end
        OP_SET: begin
          if (sel) begin
            it_we      = 1'b1;
            it_wa      = cursor_q;
            res_flag_d = 1'b1;
          end
        end
        OP_INS_AFTER, OP_INS_BEFORE: begin
          if (alloc_ok) begin
            if (free_head_q != '0) begin
              free_head_d = free_next_q;
            end else begin
              fresh_d = fresh_q + MARK_W'(1);
            end
            prev_d = (op_q == OP_INS_AFTER) ? cursor_q : c_back;
            succ_d = (op_q == OP_INS_AFTER) ? c_next : cursor_q;
            node_d = alloc_node;
            // new node: item and both own links
            it_we  = 1'b1;
            it_wa  = alloc_node;
            nx_we  = 1'b1;
            nx_wa  = alloc_node;
            nx_wd  = (op_q == OP_INS_AFTER) ? c_next : cursor_q;
            bk_we  = 1'b1;
            bk_wa  = alloc_node;
            bk_wd  = (op_q == OP_INS_AFTER) ? cursor_q : c_back;
            cursor_d          = alloc_node;
            sts_o.link_needed = 1'b1;
          end else begin
            res_full_d = 1'b1;
          end
        end
        OP_DEL_AFTER, OP_DEL_BEFORE: begin
          if (sel) begin
            // unhook the node from its neighbors
            nx_we  = 1'b1;
            nx_wa  = c_back;
            nx_wd  = c_next;
            bk_we  = 1'b1;
            bk_wa  = c_next;
            bk_wd  = c_back;
            node_d = cursor_q;
            cursor_d          = (op_q == OP_DEL_AFTER) ? c_next : c_back;
            res_flag_d        = 1'b1;
            sts_o.link_needed = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.link) begin
      if (is_insert) begin
        nx_we = 1'b1;
        nx_wa = prev_q;
        nx_wd = node_q;
        bk_we = 1'b1;
        bk_wa = succ_q;
        bk_wd = node_q;
      end else begin
        // released node goes on top of the free chain
        nx_we       = 1'b1;
        nx_wa       = node_q;
        nx_wd       = free_head_q;
        free_head_d = node_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd_i.read) begin
      cur_next_q  <= next_mem[cursor_q];
      free_next_q <= next_mem[free_head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bk_we) back_mem[bk_wa] <= bk_wd;
    if (cmd_i.read) cur_back_q <= back_mem[cursor_q];
  end

  always_ff @(posedge clk_i) begin
    if (it_we) item_mem[it_wa] <= val_q;
    if (cmd_i.read) cur_item_q <= item_mem[cursor_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      cursor_q    <= '0;
      free_head_q <= '0;
      fresh_q     <= MARK_W'(1);
      default_q   <= '0;
      done_q      <= 1'b0;
    end else begin
      if (nx_we && (nx_wa == '0)) head_q <= nx_wd;
      if (bk_we && (bk_wa == '0)) tail_q <= bk_wd;
      cursor_q    <= cursor_d;
      free_head_q <= free_head_d;
      fresh_q     <= fresh_d;
      if (cfg_we_i) default_q <= cfg_wdata_i;
      done_q      <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      val_q <= ITEM_BITS'(value_i);
    end
    node_q     <= node_d;
    prev_q     <= prev_d;
    succ_q     <= succ_d;
    res_item_q <= res_item_d;
    res_flag_q <= res_flag_d;
    res_full_q <= res_full_d;
  end

  assign done_o      = done_q;
  assign item_out_o  = res_item_q;
  assign flag_o      = res_flag_q;
  assign pool_full_o = res_full_q;

endmodule

/* hw/rtl/cursor_doubly_linked_list_core.sv */
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_core: circular cursor list with sentinel in a node pool
// done_o pulses once per accepted operation; a taking insert or delete adds a link
// step, as each link memory has one write port. start_i is taken in the done_o cycle,
// so a new operation is accepted only once the last one is done. async reset, no clear pass
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list_core #(
  parameter int unsigned POOL_NODES = cdll_pkg::POOL_NODES_DEF,
  parameter int unsigned ITEM_BITS  = cdll_pkg::ITEM_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [cdll_pkg::OP_W-1:0]          operation_i,
  input  logic signed [cdll_pkg::DATA_W-1:0] value_i,
  input  logic                               cfg_we_i,
  input  logic signed [cdll_pkg::DATA_W-1:0] cfg_wdata_i,
  output logic                               done_o,
  output logic signed [cdll_pkg::DATA_W-1:0] item_out_o,
  output logic                               flag_o,
  output logic                               pool_full_o
);
  import cdll_pkg::*;

  cdll_cmd_t cmd;
  cdll_sts_t sts;

  cdll_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  cdll_datapath #(
    .POOL_NODES (POOL_NODES),
    .ITEM_BITS  (ITEM_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (operation_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .item_out_o  (item_out_o),
    .flag_o      (flag_o),
    .pool_full_o (pool_full_o)
  );

`include "cursor_doubly_linked_list_core_assert.svh"

  `CDLL_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o && !done_o)
  `CDLL_ASSERT_SAME(a_done_idle, done_o, !busy_o)
  `CDLL_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `CDLL_ASSERT_SAME(a_flag_full_excl, done_o, !(flag_o && pool_full_o))

endmodule

/* bench/cursor_doubly_linked_list_core_tb.sv */
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_core_tb
// drives list operations through the start/busy handshake, predicts every
// done_o strobe from a local copy of the node pool and compares field by field
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list_core_tb;
  import cdll_pkg::*;

  localparam int unsigned POOL          = POOL_NODES_DEF;
  localparam int unsigned ITEM_W        = ITEM_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned TAIL_CYCLES   = 12;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd11;

  typedef logic [$clog2(POOL+1)-1:0] node_t;
  typedef logic [$clog2(POOL+1):0] mark_t;
  typedef logic signed [DATA_W-1:0] item_t;

  typedef struct packed {
    item_t item;
    logic  flag;
    logic  full;
  } list_reply_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [OP_W-1:0]   operation_i;
  item_t             value_i;
  logic              cfg_we_i;
  item_t             cfg_wdata_i;
  logic              done_o;
  item_t             item_out_o;
  logic              flag_o;
  logic              pool_full_o;

  // local copy of the list state
  node_t                  nxt_lnk [POOL+1];
  node_t                  bck_lnk [POOL+1];
  item_t                  node_val [POOL+1];
  node_t                  cur_node;
  node_t                  free_head;
  mark_t                  fresh_mark;
  item_t                  dflt_item;

  list_reply_t pending_replies[$];
  int          mismatches;
  int          ops_taken;
  int          refused_inserts;
  int          deleted_nodes;
  int          list_len;
  int          peak_len;
  int          default_writes;
  int          quiet_cycles;
  bit          gaps_on;

  cursor_doubly_linked_list_core #(
    .POOL_NODES(POOL),
    .ITEM_BITS (ITEM_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .operation_i(operation_i),
    .value_i    (value_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .item_out_o (item_out_o),
    .flag_o     (flag_o),
    .pool_full_o(pool_full_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatches++;
    // keep the log short on a badly broken build
    if (mismatches <= MAX_REPORTS) $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic predict_list_op(input logic [OP_W-1:0] op, input item_t val);
    list_reply_t r;
    node_t       n;
    node_t       prv;
    node_t       nxt;
    logic        sel;
    r   = '0;
    sel = (cur_node != '0);
    case (op)
      OP_FIRST: if (nxt_lnk[0] != '0) cur_node = nxt_lnk[0];
      OP_LAST:  if (nxt_lnk[0] != '0) cur_node = bck_lnk[0];
      OP_NONE:  r.flag = !sel;
      OP_AFTER, OP_BEFORE: begin
        if (sel) begin
          cur_node = (op == OP_AFTER) ? nxt_lnk[cur_node] : bck_lnk[cur_node];
          r.flag   = 1'b1;
        end
      end
      OP_GET: r.item = sel ? node_val[cur_node] : dflt_item;
      OP_SET: begin
        if (sel) begin
          node_val[cur_node] = val;
          r.flag             = 1'b1;
        end
      end
      OP_INS_AFTER, OP_INS_BEFORE: begin
        // recycled nodes first, then never-used ones
        n = '0;
        if (free_head != '0) begin
          n         = free_head;
          free_head = nxt_lnk[n];
        end else if (fresh_mark <= POOL) begin
          n          = node_t'(fresh_mark);
          fresh_mark = fresh_mark + mark_t'(1);
        end
        if (n == '0) begin
          r.full = 1'b1;
          refused_inserts++;
        end else begin
          if (op == OP_INS_AFTER) begin
            prv = cur_node;
            nxt = nxt_lnk[cur_node];
          end else begin
            prv = bck_lnk[cur_node];
            nxt = cur_node;
          end
          node_val[n] = val;
          nxt_lnk[n]  = nxt;
          bck_lnk[n]  = prv;
          bck_lnk[nxt] = n;
          nxt_lnk[prv] = n;
          cur_node     = n;
          list_len++;
          if (list_len > peak_len) peak_len = list_len;
        end
      end
      OP_DEL_AFTER, OP_DEL_BEFORE: begin
        if (sel) begin
          nxt = nxt_lnk[cur_node];
          prv = bck_lnk[cur_node];
          nxt_lnk[prv]      = nxt;
          bck_lnk[nxt]      = prv;
          nxt_lnk[cur_node] = free_head;
          free_head         = cur_node;
          cur_node          = (op == OP_DEL_AFTER) ? nxt : prv;
          r.flag            = 1'b1;
          list_len--;
          deleted_nodes++;
        end
      end
      default: ;
    endcase
    pending_replies.push_back(r);
  endtask

  // one transaction: optional idle gap, then hold start until busy is low
  task automatic send_op(input logic [OP_W-1:0] op, input item_t val);
    if (gaps_on && $urandom_range(0, 99) < 33) begin
      repeat ($urandom_range(1, 6)) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i     <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    do @(posedge clk_i); while (busy_o);
    ops_taken++;
    predict_list_op(op, val);
  endtask

  task automatic drain_replies();
    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_default_item(input item_t v);
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    dflt_item = v;
    default_writes++;
  endtask

  function automatic item_t pick_value();
    case ($urandom_range(0, 9))
      0:       return item_t'(32'h8000_0000);
      1:       return item_t'(32'h7fff_ffff);
      2:       return '0;
      3:       return '1;
      default: return item_t'($urandom);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_list_op(input int w_ins, input int w_del,
                                                   input int w_end, input int w_step,
                                                   input int w_acc);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_ins) return $urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE;
    r -= w_ins;
    if (r < w_del) return $urandom_range(0, 1) ? OP_DEL_AFTER : OP_DEL_BEFORE;
    r -= w_del;
    if (r < w_end) return $urandom_range(0, 1) ? OP_FIRST : OP_LAST;
    r -= w_end;
    if (r < w_step) return $urandom_range(0, 1) ? OP_AFTER : OP_BEFORE;
    r -= w_step;
    if (r < w_acc) return $urandom_range(0, 1) ? OP_GET : OP_SET;
    r -= w_acc;
    if (r < 3) return OP_NONE;
    // any code, unused ones included
    return OP_W'($urandom_range(0, 15));
  endfunction

  task automatic run_mix(input int count, input int w_ins, input int w_del,
                         input int w_end, input int w_step, input int w_acc);
    repeat (count) send_op(pick_list_op(w_ins, w_del, w_end, w_step, w_acc), pick_value());
  endtask

  // everything that needs a selection must do nothing on the empty list
  task automatic test_empty_list();
    set_default_item(item_t'(32'h8000_0000));
    send_op(OP_FIRST, '0);
    send_op(OP_LAST, '0);
    send_op(OP_NONE, '0);
    send_op(OP_AFTER, '0);
    send_op(OP_BEFORE, '0);
    send_op(OP_GET, '0);
    send_op(OP_SET, item_t'(32'h1234_5678));
    send_op(OP_DEL_AFTER, '0);
    send_op(OP_DEL_BEFORE, '0);
    for (int k = 0; k < 5; k++) send_op(OP_W'(OP_UNUSED_LO + k), '1);
  endtask

  // one-item list for first/last, inserts with nothing selected, deletes
  task automatic test_single_item();
    set_default_item(item_t'(32'h7fff_ffff));
    send_op(OP_INS_BEFORE, item_t'(32'h7fff_ffff));
    send_op(OP_AFTER, '0);
    send_op(OP_FIRST, '0);
    send_op(OP_GET, '0);
    send_op(OP_BEFORE, '0);
    drain_replies();
    send_op(OP_LAST, '0);
    send_op(OP_AFTER, '0);
    send_op(OP_INS_AFTER, item_t'(32'h8000_0000));
    send_op(OP_GET, '0);
    send_op(OP_DEL_AFTER, '0);
    send_op(OP_SET, '1);
    send_op(OP_GET, '0);
    send_op(OP_DEL_BEFORE, '0);
    send_op(OP_GET, '0);
  endtask

  // insert-heavy until the pool refuses inserts
  task automatic test_grow_to_full();
    set_default_item('1);
    run_mix(600, 65, 4, 8, 10, 10);
  endtask

  task automatic test_back_to_back();
    set_default_item(item_t'($urandom));
    gaps_on = 1'b0;
    run_mix(300, 22, 22, 12, 18, 18);
    gaps_on = 1'b1;
  endtask

  task automatic test_shrink();
    set_default_item('0);
    run_mix(500, 5, 55, 20, 8, 9);
  endtask

  task automatic test_mixed_tail();
    set_default_item(item_t'($urandom));
    run_mix(250, 25, 22, 10, 15, 18);
  endtask

  always @(posedge clk_i) begin : check_replies
    list_reply_t exp;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("result with no transaction pending");
      end else begin
        exp = pending_replies.pop_front();
        if (item_out_o !== exp.item)
          report_mismatch($sformatf("item_out %h, expected %h", item_out_o, exp.item));
        if (flag_o !== exp.flag)
          report_mismatch($sformatf("flag %b, expected %b", flag_o, exp.flag));
        if (pool_full_o !== exp.full)
          report_mismatch($sformatf("pool_full %b, expected %b", pool_full_o, exp.full));
      end
    end
  end

  // stall detector: cycles with neither an accepted transaction nor a result
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    operation_i = OP_FIRST;
    value_i     = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    quiet_cycles = 0;
    mismatches = 0;
    ops_taken = 0;
    refused_inserts = 0;
    deleted_nodes = 0;
    list_len = 0;
    peak_len = 0;
    default_writes = 0;
    gaps_on = 1'b1;
    for (int k = 0; k <= POOL; k++) begin
      nxt_lnk[k]  = '0;
      bck_lnk[k]  = '0;
      node_val[k] = '0;
    end
    cur_node   = '0;
    free_head  = '0;
    fresh_mark = mark_t'(1);
    dflt_item  = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_single_item();
    test_grow_to_full();
    test_back_to_back();
    test_shrink();
    test_mixed_tail();

    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d list operations and %0d default item writes, peak length %0d",
             ops_taken, default_writes, peak_len);
    $display("%0d inserts refused on a full pool, %0d nodes deleted",
             refused_inserts, deleted_nodes);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* cursor_doubly_linked_list_core.f */
+incdir+hw/rtl
hw/rtl/cdll_pkg.sv
hw/rtl/cdll_ctrl.sv
hw/rtl/cdll_datapath.sv
hw/rtl/cursor_doubly_linked_list_core.sv
bench/cursor_doubly_linked_list_core_tb.sv
